// ----- rtl/cts_pkg.sv -----
package cts_pkg;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 17;
  localparam int unsigned COORD_SHIFT  = 44;
  localparam int unsigned ZK_SHIFT     = 14;

  // stage map
  localparam int unsigned ST_AZI0  = 2;
  localparam int unsigned ST_SQRT0 = 3;
  localparam int unsigned ST_ROUND = ST_SQRT0 + SQRT_STEPS;
  localparam int unsigned ST_POLI  = ST_AZI0 + CORDIC_STEPS;
  localparam int unsigned ST_POL0  = ST_POLI + 1;
  localparam int unsigned ST_LAST  = ST_POL0 + CORDIC_STEPS;

  localparam logic [30:0] GAIN_Q30    = 31'd1768195364;
  localparam logic [31:0] ANG_PI      = 32'h8000_0000;
  localparam logic [31:0] ANG_HALF_PI = 32'h4000_0000;
  localparam logic [31:0] ANG_CLAMP   = 32'hC000_0000;

  typedef struct packed {
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } in_t;

  typedef struct packed {
    logic [15:0]        radius;
    logic [15:0]        polar_angle;
    logic signed [15:0] azimuth;
    logic               zero_radius;
    logic               at_pole;
  } out_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0]        ang;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [31:0]        sqx;
    logic [31:0]        sqy;
    logic [31:0]        sqz;
    logic [46:0]        prod;
    logic signed [63:0] zk;
    logic [34:0]        rem;
    logic [34:0]        root;
    cordic_t            cv;
    logic [31:0]        azi;
    out_t               res;
  } pipe_t;

  function automatic logic [31:0] atan_tab(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    cordic_t n;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 64'sd0) begin
      n.x   = c.x + dx;
      n.y   = c.y - dy;
      n.ang = c.ang + atan_tab(i);
    end else begin
      n.x   = c.x - dx;
      n.y   = c.y + dy;
      n.ang = c.ang - atan_tab(i);
    end
    return n;
  endfunction

  function automatic logic [15:0] round_angle(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h0000_8000;
    return s[31:16];
  endfunction

endpackage

// ----- rtl/cartesian_to_spherical_top.sv -----
// Throughput: one vector per cycle unless a result stalls on out_ready; 30-stage azimuth
// CORDIC, then 30-stage polar CORDIC, with a 17-stage square-root chain alongside.
// The whole pipeline holds while a finished result waits on out_ready.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
module cartesian_to_spherical_top
  import cts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  pipe_t              pipe_r   [0:ST_LAST];
  pipe_t              pipe_nxt [0:ST_LAST];
  logic [ST_LAST:0]   valid_r;
  logic               en;

  assign en        = !valid_r[ST_LAST] || out_ready;
  assign in_ready  = en;
  assign out_valid = valid_r[ST_LAST];
  assign out_data  = pipe_r[ST_LAST].res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[ST_LAST-1:0], in_valid};
    end
  end

  always_comb begin
    pipe_nxt[0]   = '0;
    pipe_nxt[0].x = in_data.vec_x;
    pipe_nxt[0].y = in_data.vec_y;
    pipe_nxt[0].z = in_data.vec_z;
  end

  for (genvar s = 1; s <= ST_LAST; s++) begin : g_stage
    always_comb begin
      logic [15:0]        ax;
      logic [15:0]        ay;
      logic [15:0]        az;
      logic signed [63:0] sx;
      logic signed [63:0] sy;
      logic signed [63:0] tk;
      logic [34:0]        bit_v;
      logic [34:0]        trial;
      logic [31:0]        pol;
      logic               zero;
      logic               pole;
      ax    = 16'(pipe_r[s-1].x < 0 ? -pipe_r[s-1].x : pipe_r[s-1].x);
      ay    = 16'(pipe_r[s-1].y < 0 ? -pipe_r[s-1].y : pipe_r[s-1].y);
      az    = 16'(pipe_r[s-1].z < 0 ? -pipe_r[s-1].z : pipe_r[s-1].z);
      sx    = 64'(pipe_r[s-1].x) <<< COORD_SHIFT;
      sy    = 64'(pipe_r[s-1].y) <<< COORD_SHIFT;
      tk    = $signed(64'(pipe_r[s-1].prod) << ZK_SHIFT);
      bit_v = '0;
      trial = '0;
      pol   = '0;
      zero  = (pipe_r[s-1].x == 0) && (pipe_r[s-1].y == 0) && (pipe_r[s-1].z == 0);
      pole  = (pipe_r[s-1].x == 0) && (pipe_r[s-1].y == 0) && !zero;
      pipe_nxt[s] = pipe_r[s-1];
      if (s == 1) begin
        pipe_nxt[s].sqx  = 32'(ax) * 32'(ax);
        pipe_nxt[s].sqy  = 32'(ay) * 32'(ay);
        pipe_nxt[s].sqz  = 32'(az) * 32'(az);
        pipe_nxt[s].prod = 47'(az) * 47'(GAIN_Q30);
        if (pipe_r[s-1].x < 0) begin
          pipe_nxt[s].cv.x   = -sx;
          pipe_nxt[s].cv.y   = -sy;
          pipe_nxt[s].cv.ang = ANG_PI;
        end else begin
          pipe_nxt[s].cv.x   = sx;
          pipe_nxt[s].cv.y   = sy;
          pipe_nxt[s].cv.ang = '0;
        end
      end
      if (s == ST_AZI0) begin
        pipe_nxt[s].rem  = 35'(pipe_r[s-1].sqx) + 35'(pipe_r[s-1].sqy)
                         + 35'(pipe_r[s-1].sqz);
        pipe_nxt[s].root = '0;
        pipe_nxt[s].zk   = (pipe_r[s-1].z < 0) ? -tk : tk;
      end
      if (s >= ST_AZI0 && s < ST_POLI) begin
        pipe_nxt[s].cv = cordic_step(pipe_r[s-1].cv, s - ST_AZI0);
      end
      if (s >= ST_SQRT0 && s < ST_ROUND) begin
        bit_v = 35'(1) << (32 - 2 * (s - ST_SQRT0));
        trial = pipe_r[s-1].root + bit_v;
        if (pipe_r[s-1].rem >= trial) begin
          pipe_nxt[s].rem  = pipe_r[s-1].rem - trial;
          pipe_nxt[s].root = (pipe_r[s-1].root >> 1) + bit_v;
        end else begin
          pipe_nxt[s].root = pipe_r[s-1].root >> 1;
        end
      end
      if (s == ST_ROUND) begin
        if (pipe_r[s-1].rem > pipe_r[s-1].root) begin
          pipe_nxt[s].root = pipe_r[s-1].root + 35'd1;
        end
      end
      if (s == ST_POLI) begin
        if (zero || pole) begin
          pipe_nxt[s].azi = '0;
        end else if (pipe_r[s-1].y == 0) begin
          pipe_nxt[s].azi = (pipe_r[s-1].x > 0) ? 32'h0 : ANG_PI;
        end else if (pipe_r[s-1].x == 0) begin
          pipe_nxt[s].azi = (pipe_r[s-1].y > 0) ? ANG_HALF_PI : 32'(0 - ANG_HALF_PI);
        end else begin
          pipe_nxt[s].azi = pipe_r[s-1].cv.ang;
        end
        if (pipe_r[s-1].zk < 0) begin
          pipe_nxt[s].cv.x   = -pipe_r[s-1].zk;
          pipe_nxt[s].cv.y   = -pipe_r[s-1].cv.x;
          pipe_nxt[s].cv.ang = ANG_PI;
        end else begin
          pipe_nxt[s].cv.x   = pipe_r[s-1].zk;
          pipe_nxt[s].cv.y   = pipe_r[s-1].cv.x;
          pipe_nxt[s].cv.ang = '0;
        end
      end
      if (s >= ST_POL0 && s < ST_LAST) begin
        pipe_nxt[s].cv = cordic_step(pipe_r[s-1].cv, s - ST_POL0);
      end
      if (s == ST_LAST) begin
        if (zero) begin
          pol = '0;
        end else if (pole) begin
          pol = (pipe_r[s-1].z > 0) ? 32'h0 : ANG_PI;
        end else if (pipe_r[s-1].z == 0) begin
          pol = ANG_HALF_PI;
        end else if (pipe_r[s-1].cv.ang > ANG_PI) begin
          pol = (pipe_r[s-1].cv.ang >= ANG_CLAMP) ? 32'h0 : ANG_PI;
        end else begin
          pol = pipe_r[s-1].cv.ang;
        end
        pipe_nxt[s].res.radius      = zero ? 16'h0 : pipe_r[s-1].root[15:0];
        pipe_nxt[s].res.polar_angle = round_angle(pol);
        pipe_nxt[s].res.azimuth     = $signed(round_angle(pipe_r[s-1].azi));
        pipe_nxt[s].res.zero_radius = zero;
        pipe_nxt[s].res.at_pole     = pole;
      end
    end
  end

  for (genvar s = 0; s <= ST_LAST; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (en) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

endmodule

// ----- tb/cts_checker.sv -----
`timescale 1ns / 100ps

module cts_checker
  import cts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  localparam logic [31:0] ARCTAN [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  localparam int unsigned EXP_DEPTH = 128;

  out_t       exp_mem [EXP_DEPTH];
  logic [6:0] exp_wr_ptr = '0;
  logic [6:0] exp_rd_ptr = '0;
  int         exp_count  = 0;

  function automatic logic [31:0] vector_angle(input logic signed [63:0] xi,
                                               input logic signed [63:0] yi,
                                               output logic signed [63:0] mag);
    logic signed [63:0] x, y, dx, dy;
    logic [31:0] ang;
    x = xi;
    y = yi;
    ang = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + ARCTAN[i];
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - ARCTAN[i];
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic logic [15:0] to_turns16(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h0000_8000;
    return s[31:16];
  endfunction

  function automatic out_t spherical_of(input in_t v);
    out_t r;
    logic signed [63:0] x, y, z, rho_k, zk, unused;
    logic [63:0] s, root, t, az;
    logic [31:0] azi, pol, a;
    x = v.vec_x;
    y = v.vec_y;
    z = v.vec_z;
    s = x * x + y * y + z * z;
    root = 0;
    for (int b = 17; b >= 0; b--)
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= s) root |= 64'd1 << b;
    if (s - root * root > root) root++;
    azi = 0;
    pol = 0;
    r = '0;
    if (x == 0 && y == 0 && z == 0) begin
      r.zero_radius = 1'b1;
    end else if (x == 0 && y == 0) begin
      r.at_pole = 1'b1;
      pol = (z > 0) ? 32'h0 : 32'h8000_0000;
    end else begin
      a = vector_angle(x <<< 44, y <<< 44, rho_k);
      if (y == 0) azi = (x > 0) ? 32'h0 : 32'h8000_0000;
      else if (x == 0) azi = (y > 0) ? 32'h4000_0000 : 32'hC000_0000;
      else azi = a;
      if (z == 0) begin
        pol = 32'h4000_0000;
      end else begin
        az = (z < 0) ? -z : z;
        t = (az * 64'd1768195364) << 14;
        zk = (z < 0) ? -$signed(t) : $signed(t);
        pol = vector_angle(zk, rho_k, unused);
        if (pol > 32'h8000_0000) pol = (pol >= 32'hC000_0000) ? 32'h0 : 32'h8000_0000;
      end
    end
    if (!r.zero_radius) r.radius = root[15:0];
    r.polar_angle = to_turns16(pol);
    r.azimuth = to_turns16(azi);
    return r;
  endfunction

  assign pending = exp_count;

  initial fail_count = 0;

  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && in_ready) begin
      exp_mem[exp_wr_ptr] = spherical_of(in_data);
      exp_wr_ptr = exp_wr_ptr + 7'd1;
      exp_count = exp_count + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (exp_count == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result transfer %h", out_data);
      end else begin
        want = exp_mem[exp_rd_ptr];
        exp_rd_ptr = exp_rd_ptr + 7'd1;
        exp_count = exp_count - 1;
        if (want !== out_data) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: exp r=%0d pol=%0d azi=%0d z=%b p=%b, got r=%0d pol=%0d azi=%0d z=%b p=%b",
                     want.radius, want.polar_angle, want.azimuth, want.zero_radius,
                     want.at_pole, out_data.radius, out_data.polar_angle,
                     out_data.azimuth, out_data.zero_radius, out_data.at_pole);
        end
      end
    end
  end

endmodule

// ----- tb/cartesian_to_spherical_top_tb.sv -----
`timescale 1ns / 100ps

module cartesian_to_spherical_top_tb;
  import cts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   burst_left = 0;

  always #5 clk = ~clk;

  cartesian_to_spherical_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  cts_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stall pattern: modes of free flow, light and heavy stalls
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_vec(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_data = '{vec_x: x, vec_y: y, vec_z: z};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sd0;
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_vec(16'sd0, 16'sd0, 16'sd0);
    send_vec(16'sd0, 16'sd0, 16'sd100);
    send_vec(16'sd0, 16'sd0, -16'sd100);
    send_vec(16'sd0, 16'sd0, 16'sh8000);
    send_vec(16'sd500, 16'sd0, 16'sd0);
    send_vec(-16'sd500, 16'sd0, 16'sd7);
    send_vec(16'sd0, 16'sd300, -16'sd9);
    send_vec(16'sd0, -16'sd300, 16'sd0);
    send_vec(16'sd3, 16'sd4, 16'sd0);
    send_vec(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_vec(16'sh8000, 16'sh8000, 16'sh8000);
    send_vec(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_vec(16'sh7FFF, 16'sh8000, 16'sd0);
    send_vec(16'sd1, 16'sd1, 16'sd1);
    send_vec(-16'sd1, -16'sd1, -16'sd1);
    send_vec(-16'sd1, 16'sd1, 16'sd0);
    send_vec(16'sd1, -16'sd1, 16'sh7FFF);
    send_vec(16'sh8000, 16'sd0, 16'sd0);
    send_vec(16'sd0, 16'sh8000, 16'sd1);
    send_vec(-16'sd200, 16'sd1, 16'sd0);
    send_vec(-16'sd200, -16'sd1, 16'sd0);
    repeat (400) send_vec(rand_coord(), rand_coord(), rand_coord());
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cts_pkg.sv
rtl/cartesian_to_spherical_top.sv
tb/cts_checker.sv
tb/cartesian_to_spherical_top_tb.sv
